// ===== sv/bbot_pkg.sv =====
// Package: face codes and configuration register indexes of the box overlap test.
`timescale 1ns / 1ps
`default_nettype none

package bbot_pkg;

   // Width of the configuration register index.
   localparam int CSR_INDEX_BITS = 3;

   // Configuration register indexes, in register order.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OWN_MIN_X    = 3'd0,
      CSR_OWN_MIN_Y    = 3'd1,
      CSR_OWN_MIN_Z    = 3'd2,
      CSR_OWN_MAX_X    = 3'd3,
      CSR_OWN_MAX_Y    = 3'd4,
      CSR_OWN_MAX_Z    = 3'd5,
      CSR_OWN_CHANNELS = 3'd6
   } csr_index_type;

   // Face codes in tie-break order.
   typedef enum logic [2:0] {
      FACE_NEG_X = 3'd0,
      FACE_POS_X = 3'd1,
      FACE_NEG_Y = 3'd2,
      FACE_POS_Y = 3'd3,
      FACE_NEG_Z = 3'd4,
      FACE_POS_Z = 3'd5
   } face_type;

   localparam int NUM_AXES = 3;

   // Per axis: the face of the own-max gap and of the other-max gap.
   localparam face_type NEG_FACE [NUM_AXES] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
   localparam face_type POS_FACE [NUM_AXES] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};

endpackage

`default_nettype wire

// ===== sv/bbot_ifs.sv =====
// Interfaces: box request, test response and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none

interface bbot_req_if #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32
);
   logic                    valid;
   logic                    ready;
   logic [COORD_BITS-1:0]   other_min_x;
   logic [COORD_BITS-1:0]   other_min_y;
   logic [COORD_BITS-1:0]   other_min_z;
   logic [COORD_BITS-1:0]   other_max_x;
   logic [COORD_BITS-1:0]   other_max_y;
   logic [COORD_BITS-1:0]   other_max_z;
   logic [CHANNEL_BITS-1:0] other_channels;

   modport source (
      output valid, other_min_x, other_min_y, other_min_z,
             other_max_x, other_max_y, other_max_z, other_channels,
      input  ready
   );
   modport sink (
      input  valid, other_min_x, other_min_y, other_min_z,
             other_max_x, other_max_y, other_max_z, other_channels,
      output ready
   );
endinterface

interface bbot_rsp_if #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32
);
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic [COORD_BITS-1:0]   depth;
   logic [2:0]              normal_axis;
   logic [CHANNEL_BITS-1:0] hit_channels;
   logic [COORD_BITS-1:0]   hit_x;
   logic [COORD_BITS-1:0]   hit_y;
   logic [COORD_BITS-1:0]   hit_z;

   modport source (
      output valid, hit, depth, normal_axis, hit_channels, hit_x, hit_y, hit_z,
      input  ready
   );
   modport sink (
      input  valid, hit, depth, normal_axis, hit_channels, hit_x, hit_y, hit_z,
      output ready
   );
endinterface

interface bbot_csr_if #(
   parameter int INDEX_BITS = 3,
   parameter int DATA_BITS  = 32
);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] reg_index;
   logic [DATA_BITS-1:0]  wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/bbot_csr_regs.sv =====
// Configuration registers holding the fixed box and its channel mask.
`timescale 1ns / 1ps
`default_nettype none

module bbot_csr_regs #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   bbot_csr_if.sink                        csr,
   output logic [2:0][COORD_BITS-1:0]      own_min,
   output logic [2:0][COORD_BITS-1:0]      own_max,
   output logic [CHANNEL_BITS-1:0]         own_channels
);
   import bbot_pkg::*;

   logic [2:0][COORD_BITS-1:0] own_min_ff;
   logic [2:0][COORD_BITS-1:0] own_max_ff;
   logic [CHANNEL_BITS-1:0]    own_channels_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_min_ff      <= '0;
         own_max_ff      <= '0;
         own_channels_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.reg_index))
            CSR_OWN_MIN_X:    own_min_ff[0]   <= csr.wdata[COORD_BITS-1:0];
            CSR_OWN_MIN_Y:    own_min_ff[1]   <= csr.wdata[COORD_BITS-1:0];
            CSR_OWN_MIN_Z:    own_min_ff[2]   <= csr.wdata[COORD_BITS-1:0];
            CSR_OWN_MAX_X:    own_max_ff[0]   <= csr.wdata[COORD_BITS-1:0];
            CSR_OWN_MAX_Y:    own_max_ff[1]   <= csr.wdata[COORD_BITS-1:0];
            CSR_OWN_MAX_Z:    own_max_ff[2]   <= csr.wdata[COORD_BITS-1:0];
            CSR_OWN_CHANNELS: own_channels_ff <= csr.wdata[CHANNEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign own_min      = own_min_ff;
   assign own_max      = own_max_ff;
   assign own_channels = own_channels_ff;

endmodule

`default_nettype wire

// ===== sv/bbot_gap_stage.sv =====
// Stage one: six face gaps, per-axis overlap bounds and shared channel mask.
`timescale 1ns / 1ps
`default_nettype none

module bbot_gap_stage #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   bbot_req_if.sink                      req,
   input  logic [2:0][COORD_BITS-1:0]    own_min,
   input  logic [2:0][COORD_BITS-1:0]    own_max,
   input  logic [CHANNEL_BITS-1:0]       own_channels,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic [5:0][COORD_BITS:0]      gap,
   output logic [2:0][COORD_BITS-1:0]    lo,
   output logic [2:0][COORD_BITS-1:0]    hi,
   output logic [CHANNEL_BITS-1:0]       shared
);

   logic                       valid_ff, valid_in;
   logic                       load;
   logic [2:0][COORD_BITS-1:0] b_min, b_max;
   logic [5:0][COORD_BITS:0]   gap_ff, gap_in;
   logic [2:0][COORD_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CHANNEL_BITS-1:0]    shared_ff, shared_in;

   assign b_min = {req.other_min_z, req.other_min_y, req.other_min_x};
   assign b_max = {req.other_max_z, req.other_max_y, req.other_max_x};

   // Advance when empty or when the next stage takes the held item.
   assign req.ready = !valid_ff || out_ready;
   assign load      = req.valid && req.ready;
   assign valid_in  = req.ready ? req.valid : valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gap_in[2*i]   = {own_max[i][COORD_BITS-1], own_max[i]}
                       - {b_min[i][COORD_BITS-1], b_min[i]};
         gap_in[2*i+1] = {b_max[i][COORD_BITS-1], b_max[i]}
                       - {own_min[i][COORD_BITS-1], own_min[i]};
         lo_in[i] = ($signed(own_min[i]) > $signed(b_min[i])) ? own_min[i] : b_min[i];
         hi_in[i] = ($signed(own_max[i]) < $signed(b_max[i])) ? own_max[i] : b_max[i];
      end
      shared_in = own_channels & req.other_channels;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gap_ff    <= gap_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         shared_ff <= shared_in;
      end
   end

   assign out_valid = valid_ff;
   assign gap       = gap_ff;
   assign lo        = lo_ff;
   assign hi        = hi_ff;
   assign shared    = shared_ff;

endmodule

`default_nettype wire

// ===== sv/bbot_reduce_stage.sv =====
// Stage two: hit decision, first level of the gap minimum, overlap centres.
`timescale 1ns / 1ps
`default_nettype none

module bbot_reduce_stage #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [5:0][COORD_BITS:0]      gap,
   input  logic [2:0][COORD_BITS-1:0]    lo,
   input  logic [2:0][COORD_BITS-1:0]    hi,
   input  logic [CHANNEL_BITS-1:0]       shared,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic                          hit,
   output logic [2:0][COORD_BITS:0]      win_gap,
   output bbot_pkg::face_type [2:0]      win_face,
   output logic [2:0][COORD_BITS-1:0]    centre,
   output logic [CHANNEL_BITS-1:0]       shared_out
);
   import bbot_pkg::*;

   logic                       valid_ff, valid_in;
   logic                       load;
   logic                       hit_ff, hit_in;
   logic [2:0][COORD_BITS:0]   win_gap_ff, win_gap_in;
   face_type [2:0]             win_face_ff, win_face_in;
   logic [2:0][COORD_BITS-1:0] centre_ff, centre_in;
   logic [CHANNEL_BITS-1:0]    shared_ff;
   logic [COORD_BITS:0]        sum;
   logic                       any_negative;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      sum          = '0;
      any_negative = 1'b0;
      for (int i = 0; i < 6; i++) begin
         any_negative = any_negative | gap[i][COORD_BITS];
      end
      hit_in = (|shared) && !any_negative;
      for (int i = 0; i < 3; i++) begin
         // Strictly smaller wins, so the earlier face keeps a tie.
         if ($signed(gap[2*i+1]) < $signed(gap[2*i])) begin
            win_gap_in[i]  = gap[2*i+1];
            win_face_in[i] = POS_FACE[i];
         end else begin
            win_gap_in[i]  = gap[2*i];
            win_face_in[i] = NEG_FACE[i];
         end
         // Floor halving: drop the low bit of the widened sum.
         sum          = {lo[i][COORD_BITS-1], lo[i]} + {hi[i][COORD_BITS-1], hi[i]};
         centre_in[i] = sum[COORD_BITS:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff      <= hit_in;
         win_gap_ff  <= win_gap_in;
         win_face_ff <= win_face_in;
         centre_ff   <= centre_in;
         shared_ff   <= shared;
      end
   end

   assign out_valid  = valid_ff;
   assign hit        = hit_ff;
   assign win_gap    = win_gap_ff;
   assign win_face   = win_face_ff;
   assign centre     = centre_ff;
   assign shared_out = shared_ff;

endmodule

`default_nettype wire

// ===== sv/bbot_select_stage.sv =====
// Stage three: final gap minimum, zeroing on a miss, response output register.
`timescale 1ns / 1ps
`default_nettype none

module bbot_select_stage #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          hit,
   input  logic [2:0][COORD_BITS:0]      win_gap,
   input  bbot_pkg::face_type [2:0]      win_face,
   input  logic [2:0][COORD_BITS-1:0]    centre,
   input  logic [CHANNEL_BITS-1:0]       shared,
   bbot_rsp_if.source                    rsp
);
   import bbot_pkg::*;

   logic                       valid_ff, valid_in;
   logic                       load;
   logic                       hit_ff;
   logic [COORD_BITS-1:0]      depth_ff, depth_in;
   face_type                   face_ff, face_in;
   logic [CHANNEL_BITS-1:0]    channels_ff, channels_in;
   logic [2:0][COORD_BITS-1:0] centre_ff, centre_in;
   logic                       lt_10, lt_20, lt_21;
   logic [COORD_BITS:0]        best_gap;

   assign in_ready = !valid_ff || rsp.ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Three compares side by side, then pick; earlier face keeps ties.
   assign lt_10 = $signed(win_gap[1]) < $signed(win_gap[0]);
   assign lt_20 = $signed(win_gap[2]) < $signed(win_gap[0]);
   assign lt_21 = $signed(win_gap[2]) < $signed(win_gap[1]);

   always_comb begin
      priority if (!lt_10 && !lt_20) begin
         best_gap = win_gap[0];
         face_in  = win_face[0];
      end else if (lt_10 && !lt_21) begin
         best_gap = win_gap[1];
         face_in  = win_face[1];
      end else begin
         best_gap = win_gap[2];
         face_in  = win_face[2];
      end
      depth_in    = best_gap[COORD_BITS-1:0];
      channels_in = shared;
      centre_in   = centre;
      if (!hit) begin
         depth_in    = '0;
         face_in     = FACE_NEG_X;
         channels_in = '0;
         centre_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff      <= hit;
         depth_ff    <= depth_in;
         face_ff     <= face_in;
         channels_ff <= channels_in;
         centre_ff   <= centre_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.hit          = hit_ff;
   assign rsp.depth        = depth_ff;
   assign rsp.normal_axis  = face_ff;
   assign rsp.hit_channels = channels_ff;
   assign rsp.hit_x        = centre_ff[0];
   assign rsp.hit_y        = centre_ff[1];
   assign rsp.hit_z        = centre_ff[2];

endmodule

`default_nettype wire

// ===== sv/box_box_overlap_test_unit.sv =====
// Top level: fixed box versus streamed box overlap test with minimum penetration face.
// Pipeline: registered gap, reduce and select stages; the response is valid on rsp_chan
// from the select stage register. Throughput: one box per cycle while rsp_chan
// takes responses; each stage holds one item and the stages advance independently,
// so bubbles are squeezed out while the output waits to be taken.
// Reset: synchronous, active high; empties the pipeline and clears all configuration
// registers to zero. No clearing pass; requests are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module box_box_overlap_test_unit #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32,
   parameter int CSR_DATA_BITS = (COORD_BITS > CHANNEL_BITS) ? COORD_BITS : CHANNEL_BITS
) (
   input  logic       clock,
   input  logic       reset,
   bbot_csr_if.sink   csr_chan,
   bbot_req_if.sink   req_chan,
   bbot_rsp_if.source rsp_chan
);
   import bbot_pkg::*;

   // Fixed box; user must write it via configuration channel while idle; not enforced.
   logic [2:0][COORD_BITS-1:0] own_min, own_max;
   logic [CHANNEL_BITS-1:0]    own_channels;

   // Stage one to stage two.
   logic                       s1_valid, s1_ready;
   logic [5:0][COORD_BITS:0]   s1_gap;
   logic [2:0][COORD_BITS-1:0] s1_lo, s1_hi;
   logic [CHANNEL_BITS-1:0]    s1_shared;

   // Stage two to stage three.
   logic                       s2_valid, s2_ready;
   logic                       s2_hit;
   logic [2:0][COORD_BITS:0]   s2_win_gap;
   face_type [2:0]             s2_win_face;
   logic [2:0][COORD_BITS-1:0] s2_centre;
   logic [CHANNEL_BITS-1:0]    s2_shared;

   // Hold the fixed box; every index outside the list is dropped.
   bbot_csr_regs #(
      .COORD_BITS   (COORD_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_csr_regs (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_chan),
      .own_min      (own_min),
      .own_max      (own_max),
      .own_channels (own_channels)
   );

   // Gaps are formed one bit wider than a coordinate so they are exact;
   // overlap bounds per axis are the larger minimum and the smaller maximum.
   bbot_gap_stage #(
      .COORD_BITS   (COORD_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_gap_stage (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .own_min      (own_min),
      .own_max      (own_max),
      .own_channels (own_channels),
      .out_ready    (s1_ready),
      .out_valid    (s1_valid),
      .gap          (s1_gap),
      .lo           (s1_lo),
      .hi           (s1_hi),
      .shared       (s1_shared)
   );

   // Decide the hit from the gap signs and the shared mask, reduce the six
   // gaps to three per-axis winners and halve the bound sums (floor).
   bbot_reduce_stage #(
      .COORD_BITS   (COORD_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_reduce_stage (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .gap          (s1_gap),
      .lo           (s1_lo),
      .hi           (s1_hi),
      .shared       (s1_shared),
      .out_ready    (s2_ready),
      .out_valid    (s2_valid),
      .hit          (s2_hit),
      .win_gap      (s2_win_gap),
      .win_face     (s2_win_face),
      .centre       (s2_centre),
      .shared_out   (s2_shared)
   );

   // Pick the smallest of the three winners, zero every field on a miss and
   // hold the result in the output register until the transfer completes.
   bbot_select_stage #(
      .COORD_BITS   (COORD_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_select_stage (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid),
      .in_ready     (s2_ready),
      .hit          (s2_hit),
      .win_gap      (s2_win_gap),
      .win_face     (s2_win_face),
      .centre       (s2_centre),
      .shared       (s2_shared),
      .rsp          (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== sv/bbot_checker.sv =====
// Checker on the response port of the box overlap test, and its bind.
`timescale 1ns / 1ps
`default_nettype none

module bbot_checker #(
   parameter int COORD_BITS   = 32,
   parameter int CHANNEL_BITS = 32
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    hit,
   input logic [COORD_BITS-1:0]   depth,
   input logic [2:0]              normal_axis,
   input logic [CHANNEL_BITS-1:0] hit_channels
);
   import bbot_pkg::*;

   // A miss carries nothing but zeros.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !hit |-> depth == '0 && normal_axis == FACE_NEG_X && hit_channels == '0)
      else $error("miss response carries non-zero fields");

   // A hit needs at least one shared channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && hit |-> hit_channels != '0)
      else $error("hit response without shared channels");

   // Face code stays within the six faces.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> normal_axis <= FACE_POS_Z)
      else $error("normal axis out of range");

   // Pipeline is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(depth)
                                 && $stable(normal_axis) && $stable(hit_channels))
      else $error("stalled response changed");

endmodule

bind box_box_overlap_test_unit bbot_checker #(
   .COORD_BITS   (COORD_BITS),
   .CHANNEL_BITS (CHANNEL_BITS)
) u_bbot_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .hit          (rsp_chan.hit),
   .depth        (rsp_chan.depth),
   .normal_axis  (rsp_chan.normal_axis),
   .hit_channels (rsp_chan.hit_channels)
);

`default_nettype wire
